/* src/rgbycc_pkg.sv */
`default_nettype none

package rgbycc_pkg;

  // Fractional bits of the fixed-point coefficients.
  localparam int COEF_FRAC_BITS = 16;

  // Coefficients are all below 2.0, so F+1 magnitude bits and a zero sign bit suffice.
  localparam int CoefW   = COEF_FRAC_BITS + 2;
  // A byte times a coefficient.
  localparam int ProdW   = COEF_FRAC_BITS + 9;
  // Signed chroma in Q(F), wide enough for any signed sum of three products.
  localparam int ChromaW = COEF_FRAC_BITS + 10;
  // Signed Q(2F) results before clamping.
  localparam int WideW   = 2 * COEF_FRAC_BITS + 12;

  // Register stages from input to output, output register included.
  localparam int PipeDepth = 5;

  typedef logic [CoefW-1:0] coef_t;

  // Coefficient given in millionths, scaled by 2^F and rounded to nearest.
  function automatic coef_t qcoef(input longint millionths);
    longint scaled;
    scaled = (millionths * (longint'(1) << COEF_FRAC_BITS) + 500000) / 1000000;
    return coef_t'(scaled);
  endfunction

  localparam coef_t KYr   = qcoef(299000);
  localparam coef_t KYg   = qcoef(587000);
  localparam coef_t KYb   = qcoef(114000);
  localparam coef_t KCbr  = qcoef(168736);
  localparam coef_t KCbg  = qcoef(331264);
  localparam coef_t KHalf = qcoef(500000);
  localparam coef_t KCrg  = qcoef(418688);
  localparam coef_t KCrb  = qcoef(81312);
  localparam coef_t KRcr  = qcoef(1402000);
  localparam coef_t KGcb  = qcoef(344136);
  localparam coef_t KGcr  = qcoef(714136);
  localparam coef_t KBcb  = qcoef(1772000);

  // Conversion modes.
  typedef enum logic [1:0] {
    MODE_RGB2YCC = 2'd0,
    MODE_LUMA    = 2'd1,
    MODE_YCC2RGB = 2'd2,
    MODE_EMBED   = 2'd3
  } mode_e;

endpackage

`default_nettype wire

/* src/rgb_ycbcr_converter_core.sv */
`default_nettype none

// Channel  | Direction | Handshake               | Payload
// request  | in        | in_valid_i / in_stall_o | comp_first_i, comp_second_i, comp_third_i,
//          |           |                         | luma_in_i
// result   | out       | out_valid_o/out_stall_i | out_first_o, out_second_o, out_third_o
// config   | in        | cfg_we_i                | cfg_wdata_i (mode)
//
// One request enters every cycle while in_stall_o is low; its result passes through five
// register stages (products, sums, chroma products, Q(2F) sums, and clamp and round into
// the output register).
// Reset clears the valid bits of every stage and sets the mode to RGB to YCbCr.
// A stall on the result side holds only the stages that are full behind it; empty stages
// keep filling, so in_stall_o rises only with a full pipeline.

module rgb_ycbcr_converter_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] comp_first_i,
  input  wire logic [7:0] comp_second_i,
  input  wire logic [7:0] comp_third_i,
  input  wire logic [7:0] luma_in_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_first_o,
  output logic [7:0]      out_second_o,
  output logic [7:0]      out_third_o
);
  import rgbycc_pkg::*;

  localparam int F2 = 2 * COEF_FRAC_BITS;
  localparam logic signed [ChromaW-1:0] ChromaOff =
    ChromaW'(longint'(128) << COEF_FRAC_BITS);
  localparam logic signed [WideW-1:0] ClampTop = WideW'(longint'(255) << F2);
  localparam logic signed [WideW-1:0] RoundHalf = WideW'(longint'(1) << (F2 - 1));

  // Clamp a Q(2F) value to 0..255 and round half up.
  function automatic logic [7:0] clamp_round(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] rnd;
    rnd = v + RoundHalf;
    priority if (v[WideW-1]) begin
      return 8'd0;
    end else if (v > ClampTop) begin
      return 8'hFF;
    end else begin
      return rnd[F2+7:F2];
    end
  endfunction

  // Mode register.
  mode_e mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RGB2YCC;
    end else if (cfg_we_i) begin
      mode_q <= mode_e'(cfg_wdata_i);
    end
  end

  // Stage enables: a stage loads when it is empty or the stage after it moves on.
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_q || !out_stall_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // Stage 1: byte by coefficient products, and the offset-free chroma for YCbCr input.
  logic [ProdW-1:0] p_yr_d, p_yg_d, p_yb_d, p_cbr_d, p_cbg_d, p_cbb_d;
  logic [ProdW-1:0] p_crr_d, p_crg_d, p_crb_d;
  logic [ProdW-1:0] p_yr_q, p_yg_q, p_yb_q, p_cbr_q, p_cbg_q, p_cbb_q;
  logic [ProdW-1:0] p_crr_q, p_crg_q, p_crb_q;
  logic signed [7:0] ycc_cb_d, ycc_cr_d, ycc_cb_q, ycc_cr_q;
  logic [7:0] y_byte_d, y1_byte_q;
  mode_e mode1_q;

  always_comb begin
    p_yr_d  = ProdW'(comp_first_i)  * ProdW'(KYr);
    p_yg_d  = ProdW'(comp_second_i) * ProdW'(KYg);
    p_yb_d  = ProdW'(comp_third_i)  * ProdW'(KYb);
    p_cbr_d = ProdW'(comp_first_i)  * ProdW'(KCbr);
    p_cbg_d = ProdW'(comp_second_i) * ProdW'(KCbg);
    p_cbb_d = ProdW'(comp_third_i)  * ProdW'(KHalf);
    p_crr_d = ProdW'(comp_first_i)  * ProdW'(KHalf);
    p_crg_d = ProdW'(comp_second_i) * ProdW'(KCrg);
    p_crb_d = ProdW'(comp_third_i)  * ProdW'(KCrb);
    // Subtracting 128 from a byte is a flip of its top bit read as signed.
    ycc_cb_d = $signed(comp_second_i ^ 8'h80);
    ycc_cr_d = $signed(comp_third_i ^ 8'h80);
    y_byte_d = (mode_q == MODE_YCC2RGB) ? comp_first_i : luma_in_i;
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      p_yr_q    <= p_yr_d;
      p_yg_q    <= p_yg_d;
      p_yb_q    <= p_yb_d;
      p_cbr_q   <= p_cbr_d;
      p_cbg_q   <= p_cbg_d;
      p_cbb_q   <= p_cbb_d;
      p_crr_q   <= p_crr_d;
      p_crg_q   <= p_crg_d;
      p_crb_q   <= p_crb_d;
      ycc_cb_q  <= ycc_cb_d;
      ycc_cr_q  <= ycc_cr_d;
      y1_byte_q <= y_byte_d;
      mode1_q   <= mode_q;
    end
  end

  // Stage 2: luma and offset-free chroma sums in Q(F); YCbCr input chroma is only shifted to Q(F).
  logic [ProdW-1:0] y_f_d, y_f_q;
  logic signed [ChromaW-1:0] cb_d, cr_d, cb_q, cr_q;
  logic [7:0] y2_byte_q;
  mode_e mode2_q;

  always_comb begin
    y_f_d = p_yr_q + p_yg_q + p_yb_q;
    if (mode1_q == MODE_YCC2RGB) begin
      cb_d = ChromaW'(ycc_cb_q) <<< COEF_FRAC_BITS;
      cr_d = ChromaW'(ycc_cr_q) <<< COEF_FRAC_BITS;
    end else begin
      cb_d = $signed({1'b0, p_cbb_q}) - $signed({1'b0, p_cbr_q}) - $signed({1'b0, p_cbg_q});
      cr_d = $signed({1'b0, p_crr_q}) - $signed({1'b0, p_crg_q}) - $signed({1'b0, p_crb_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      y_f_q     <= y_f_d;
      cb_q      <= cb_d;
      cr_q      <= cr_d;
      y2_byte_q <= y1_byte_q;
      mode2_q   <= mode1_q;
    end
  end

  // Stage 3: chroma by inverse coefficients in Q(2F); forward results get their offset.
  logic signed [WideW-1:0] m_r_d, m_gb_d, m_gr_d, m_b_d;
  logic signed [WideW-1:0] m_r_q, m_gb_q, m_gr_q, m_b_q;
  logic signed [ChromaW-1:0] fwd0_d, fwd1_d, fwd2_d, fwd0_q, fwd1_q, fwd2_q;
  logic [7:0] y3_byte_q;
  mode_e mode3_q;

  always_comb begin
    m_r_d  = WideW'(cr_q) * WideW'($signed(KRcr));
    m_gb_d = WideW'(cb_q) * WideW'($signed(KGcb));
    m_gr_d = WideW'(cr_q) * WideW'($signed(KGcr));
    m_b_d  = WideW'(cb_q) * WideW'($signed(KBcb));
    fwd0_d = $signed({1'b0, y_f_q});
    fwd1_d = cb_q + ChromaOff;
    fwd2_d = cr_q + ChromaOff;
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      m_r_q     <= m_r_d;
      m_gb_q    <= m_gb_d;
      m_gr_q    <= m_gr_d;
      m_b_q     <= m_b_d;
      fwd0_q    <= fwd0_d;
      fwd1_q    <= fwd1_d;
      fwd2_q    <= fwd2_d;
      y3_byte_q <= y2_byte_q;
      mode3_q   <= mode2_q;
    end
  end

  // Stage 4: all three results brought to Q(2F).
  logic signed [WideW-1:0] yw;
  logic signed [WideW-1:0] r0_d, r1_d, r2_d, r0_q, r1_q, r2_q;
  mode_e mode4_q;

  always_comb begin
    yw = $signed(WideW'(y3_byte_q) << F2);
    if (mode3_q == MODE_RGB2YCC || mode3_q == MODE_LUMA) begin
      r0_d = WideW'(fwd0_q) <<< COEF_FRAC_BITS;
      r1_d = WideW'(fwd1_q) <<< COEF_FRAC_BITS;
      r2_d = WideW'(fwd2_q) <<< COEF_FRAC_BITS;
    end else begin
      r0_d = yw + m_r_q;
      r1_d = yw - m_gb_q - m_gr_q;
      r2_d = yw + m_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      r0_q    <= r0_d;
      r1_q    <= r1_d;
      r2_q    <= r2_d;
      mode4_q <= mode3_q;
    end
  end

  // Stage 5: clamp, round and load the output register; luma mode zeroes the second and third outputs.
  logic [7:0] o0_d, o1_d, o2_d, o0_q, o1_q, o2_q;

  always_comb begin
    o0_d = clamp_round(r0_q);
    o1_d = clamp_round(r1_q);
    o2_d = clamp_round(r2_q);
    if (mode4_q == MODE_LUMA) begin
      o1_d = 8'd0;
      o2_d = 8'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      o0_q <= o0_d;
      o1_q <= o1_d;
      o2_q <= o2_d;
    end
  end

  assign out_valid_o  = v5_q;
  assign out_first_o  = o0_q;
  assign out_second_o = o1_q;
  assign out_third_o  = o2_q;

endmodule

`default_nettype wire

/* src/rgbycc_checker.sv */
`default_nettype none

module rgbycc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] out_first_o,
  input wire logic [7:0] out_second_o,
  input wire logic [7:0] out_third_o
);
  import rgbycc_pkg::*;

  // Requests inside the block: accepted minus delivered.
  logic [3:0] occ_d, occ_q;
  logic in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign occ_d   = occ_q + {3'b000, in_acc} - {3'b000, out_acc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 4'd0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // The output side comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid straight after reset");

  // A stalled result keeps its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_first_o)
      && $stable(out_second_o) && $stable(out_third_o))
    else $error("stalled result changed");

  // The input is held back only by a stalled, full output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("request stalled without a stalled result");

  // No more requests in flight than there are stages.
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= 4'(PipeDepth))
    else $error("more requests in flight than pipeline stages");

  // A result is only shown for a request that was taken in.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occ_q != 4'd0)
    else $error("result without an outstanding request");

endmodule

bind rgb_ycbcr_converter_core rgbycc_checker u_rgbycc_checker (.*);

`default_nettype wire
